FILE: design/psg_to_apu_register_translator_macros.svh
// Assertion macros shared by the translator's checker.
`ifndef PSG_TO_APU_REGISTER_TRANSLATOR_MACROS_SVH
`define PSG_TO_APU_REGISTER_TRANSLATOR_MACROS_SVH

// Check a property on every edge outside reset.
`define PSGAPU_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check an implication on every edge outside reset.
`define PSGAPU_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a property on every edge, reset included.
`define PSGAPU_ASSERT_NORST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: design/psgapu_pkg.sv
// Shared types, codes and constants of the PSG to APU register translator.
package psgapu_pkg;

    // PSG channel codes
    localparam logic [1:0] CH_PULSE0 = 2'd0;
    localparam logic [1:0] CH_PULSE1 = 2'd1;
    localparam logic [1:0] CH_TRI    = 2'd2;
    localparam logic [1:0] CH_NOISE  = 2'd3;

    // APU register offsets from the base address
    localparam logic [3:0] OFS_PULSE0_VOL = 4'h0;
    localparam logic [3:0] OFS_PULSE0_LO  = 4'h2;
    localparam logic [3:0] OFS_PULSE0_HI  = 4'h3;
    localparam logic [3:0] OFS_PULSE1_VOL = 4'h4;
    localparam logic [3:0] OFS_PULSE1_LO  = 4'h6;
    localparam logic [3:0] OFS_PULSE1_HI  = 4'h7;
    localparam logic [3:0] OFS_TRI_GATE   = 4'h8;
    localparam logic [3:0] OFS_TRI_LO     = 4'hA;
    localparam logic [3:0] OFS_TRI_HI     = 4'hB;
    localparam logic [3:0] OFS_NOISE_VOL  = 4'hC;
    localparam logic [3:0] OFS_NOISE_MODE = 4'hE;
    localparam logic [3:0] OFS_NOISE_LEN  = 4'hF;

    // Fixed data patterns
    localparam logic [7:0] PULSE_VOL_BASE = 8'hB0;
    localparam logic [7:0] NOISE_VOL_BASE = 8'h30;
    localparam logic [7:0] PERIOD_HI_BASE = 8'hF8;
    localparam logic [7:0] NOISE_LEN_DATA = 8'hF8;
    localparam logic [7:0] NOISE_MODE_BIT = 8'h80;
    localparam logic [7:0] TRI_GATE_ON    = 8'hFF;
    localparam logic [7:0] TRI_GATE_OFF   = 8'h00;
    localparam logic [3:0] ATTEN_SILENT   = 4'hF;

    // Job queue geometry
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    // One APU register write
    typedef struct packed {
        logic [3:0] offset;
        logic [7:0] data;
    } t_wr;

    // Writes caused by one PSG byte; last_idx names the final one
    typedef struct packed {
        logic [1:0]     last_idx;
        t_wr  [2:0]     wr;
    } t_job;

    // Noise rate map
    function automatic logic [7:0] noise_rate(input logic [1:0] sel);
        logic [7:0] r;
        case (sel)
            2'd0:    r = 8'd4;
            2'd1:    r = 8'd8;
            2'd2:    r = 8'd12;
            default: r = 8'd14;
        endcase
        return r;
    endfunction

endpackage

FILE: design/psgapu_if.sv
// Valid/ready channel interfaces for PSG bytes in and APU writes out.
interface psgapu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] psg_byte;

    modport source (output valid, output psg_byte, input ready);
    modport sink   (input valid, input psg_byte, output ready);
endinterface

interface psgapu_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] reg_offset;
    logic [7:0] reg_data;
    logic       last;

    modport source (output valid, output reg_offset, output reg_data, output last,
                    input ready);
    modport sink   (input valid, input reg_offset, input reg_data, input last,
                    output ready);
endinterface

FILE: design/psgapu_front.sv
// Front end: takes PSG bytes, updates the register copy, builds write jobs.
module psgapu_front
    import psgapu_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    psgapu_in_if.sink         i_in,
    input  logic              i_q_full,
    output logic              o_q_push,
    output t_job              o_q_job
);

    logic [1:0] r_ch;
    logic       r_isvol;
    logic [9:0] r_tone [3];
    logic [3:0] r_att  [4];
    logic [2:0] r_nctl;

    logic       is_latch;
    logic       accept;
    logic [1:0] ch;
    logic       isvol;
    logic [3:0] att_new;
    logic [2:0] nctl_new;
    logic [9:0] tone_old;
    logic [9:0] tone_new;
    logic [9:0] period;
    logic [9:0] tri_half;
    logic [7:0] rate;
    t_job       job;

    assign i_in.ready = !i_q_full;
    assign accept     = i_in.valid && !i_q_full;
    assign is_latch   = i_in.psg_byte[7];
    assign ch         = is_latch ? i_in.psg_byte[6:5] : r_ch;
    assign isvol      = is_latch ? i_in.psg_byte[4] : r_isvol;

    // Select the stored tone of the addressed channel
    always_comb begin
        case (ch)
            CH_PULSE0: tone_old = r_tone[0];
            CH_PULSE1: tone_old = r_tone[1];
            default:   tone_old = r_tone[2];
        endcase
    end

    // Form the updated register values seen by this beat
    assign att_new  = isvol ? i_in.psg_byte[3:0] : r_att[ch];
    assign nctl_new = (!isvol && ch == CH_NOISE) ? i_in.psg_byte[2:0] : r_nctl;
    assign tone_new = is_latch ? {tone_old[9:4], i_in.psg_byte[3:0]}
                               : {i_in.psg_byte[5:0], tone_old[3:0]};
    assign tri_half = {1'b0, tone_new[9:1]};
    assign rate     = noise_rate(nctl_new[1:0]);

    // Pulse period is N-1, triangle period N/2-1, both clamped at zero
    always_comb begin
        if (ch == CH_TRI) begin
            period = (tone_new > 10'd1) ? tri_half - 10'd1 : '0;
        end else begin
            period = (tone_new != '0) ? tone_new - 10'd1 : '0;
        end
    end

    // Build the write job for the latched channel
    always_comb begin
        job = '0;
        unique case (ch)
            CH_NOISE: begin
                job.last_idx     = 2'd2;
                job.wr[0].offset = OFS_NOISE_VOL;
                job.wr[0].data   = NOISE_VOL_BASE | {4'd0, ~att_new};
                job.wr[1].offset = OFS_NOISE_MODE;
                job.wr[1].data   = (nctl_new[2] ? 8'd0 : NOISE_MODE_BIT) | rate;
                job.wr[2].offset = OFS_NOISE_LEN;
                job.wr[2].data   = NOISE_LEN_DATA;
            end
            CH_TRI: begin
                if (isvol) begin
                    job.last_idx     = 2'd0;
                    job.wr[0].offset = OFS_TRI_GATE;
                    job.wr[0].data   = (att_new == ATTEN_SILENT) ? TRI_GATE_OFF : TRI_GATE_ON;
                end else begin
                    job.last_idx     = 2'd1;
                    job.wr[0].offset = OFS_TRI_LO;
                    job.wr[0].data   = period[7:0];
                    job.wr[1].offset = OFS_TRI_HI;
                    job.wr[1].data   = PERIOD_HI_BASE | {6'd0, period[9:8]};
                end
            end
            default: begin
                if (isvol) begin
                    job.last_idx     = 2'd0;
                    job.wr[0].offset = (ch == CH_PULSE0) ? OFS_PULSE0_VOL : OFS_PULSE1_VOL;
                    job.wr[0].data   = PULSE_VOL_BASE | {4'd0, ~att_new};
                end else begin
                    job.last_idx     = 2'd1;
                    job.wr[0].offset = (ch == CH_PULSE0) ? OFS_PULSE0_LO : OFS_PULSE1_LO;
                    job.wr[0].data   = period[7:0];
                    job.wr[1].offset = (ch == CH_PULSE0) ? OFS_PULSE0_HI : OFS_PULSE1_HI;
                    job.wr[1].data   = PERIOD_HI_BASE | {6'd0, period[9:8]};
                end
            end
        endcase
    end

    assign o_q_push = accept;
    assign o_q_job  = job;

    // Update the PSG register copy on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ch    <= CH_PULSE0;
            r_isvol <= 1'b0;
            r_nctl  <= '0;
            for (int i = 0; i < 3; i++) begin
                r_tone[i] <= '0;
            end
            for (int i = 0; i < 4; i++) begin
                r_att[i] <= ATTEN_SILENT;
            end
        end else if (accept) begin
            r_ch    <= ch;
            r_isvol <= isvol;
            r_nctl  <= nctl_new;
            if (isvol) begin
                r_att[ch] <= att_new;
            end else if (ch != CH_NOISE) begin
                r_tone[ch] <= tone_new;
            end
        end
    end

endmodule

FILE: design/psgapu_fifo.sv
// Short job queue between the front and back ends.
module psgapu_fifo
    import psgapu_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_job o_head
);

    t_job         r_mem [QDEPTH];
    logic [QAW:0] r_wp;
    logic [QAW:0] r_rp;
    logic         do_push;
    logic         do_pop;

    assign o_empty = (r_wp == r_rp);
    assign o_full  = (r_wp[QAW-1:0] == r_rp[QAW-1:0]) && (r_wp[QAW] != r_rp[QAW]);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_head  = r_mem[r_rp[QAW-1:0]];

    // Store incoming jobs
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp[QAW-1:0]] <= i_job;
        end
    end

    // Advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
        end
    end

endmodule

FILE: design/psgapu_back.sv
// Back end: plays each queued job out as APU write beats, one per cycle while the output takes them.
module psgapu_back
    import psgapu_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_q_empty,
    input  t_job         i_q_head,
    output logic         o_q_pop,
    psgapu_out_if.source o_out
);

    logic [1:0] r_idx;
    logic       r_valid;
    logic [3:0] r_offset;
    logic [7:0] r_data;
    logic       r_last;

    logic       load;
    logic       at_last;
    t_wr        cur;

    assign load    = !i_q_empty && (!r_valid || o_out.ready);
    assign at_last = (r_idx == i_q_head.last_idx);
    assign o_q_pop = load && at_last;

    // Pick the current write of the head job
    always_comb begin
        case (r_idx)
            2'd0:    cur = i_q_head.wr[0];
            2'd1:    cur = i_q_head.wr[1];
            default: cur = i_q_head.wr[2];
        endcase
    end

    // Step through the writes of the head job
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_idx <= at_last ? 2'd0 : r_idx + 2'd1;
            end
            if (load) begin
                r_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Hold the output beat until taken
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_offset <= cur.offset;
            r_data   <= cur.data;
            r_last   <= at_last;
        end
    end

    assign o_out.valid      = r_valid;
    assign o_out.reg_offset = r_offset;
    assign o_out.reg_data   = r_data;
    assign o_out.last       = r_last;

endmodule

FILE: design/psg_to_apu_register_translator.sv
// Top level of the PSG latch/data to APU register write translator.
//
//  Channel  Dir  Payload                          Beat
//  i_in     in   psg_byte[7:0]                    one PSG write byte
//  o_out    out  reg_offset[3:0] reg_data[7:0]    one APU register write
//                last
//
//  A byte is taken in any cycle the four-entry job queue has room.
//  Each byte yields one to three write beats, one per cycle from the back
//  end while the output is not stalled.
//  The first write passes through the job queue and the output register.
//  Reset (synchronous, active low) empties the queue and restores the
//  PSG register copy; output stalls fill the queue, which then holds off bytes.
module psg_to_apu_register_translator
    import psgapu_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    psgapu_in_if.sink    i_in,
    psgapu_out_if.source o_out
);

    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_empty;
    t_job q_job;
    t_job q_head;

    psgapu_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_job  (q_job)
    );

    psgapu_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    psgapu_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_head  (q_head),
        .o_q_pop   (q_pop),
        .o_out     (o_out)
    );

endmodule

FILE: design/psgapu_checker.sv
// Port-level checks of the translator, bound to the top level.
`include "psg_to_apu_register_translator_macros.svh"

module psgapu_checker
    import psgapu_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [3:0] i_out_offset,
    input logic [7:0] i_out_data,
    input logic       i_out_last
);

    logic out_acc;
    assign out_acc = i_out_valid && i_out_ready;

    // A stalled write beat stays offered
    `PSGAPU_ASSERT_IMPLY(a_out_hold, i_clk, i_rst_n,
        $past(i_out_valid && !i_out_ready), i_out_valid, "output beat dropped while stalled")

    // Reset leaves no write beat on the output
    `PSGAPU_ASSERT_NORST(a_rst_idle, i_clk, !i_rst_n |=> !i_out_valid, "output valid after reset")

    // Noise length write closes its group with the fixed pattern
    `PSGAPU_ASSERT_IMPLY(a_noise_len, i_clk, i_rst_n,
        out_acc && i_out_offset == OFS_NOISE_LEN,
        i_out_last && i_out_data == NOISE_LEN_DATA, "bad noise length write")

    // Noise volume write never ends a group
    `PSGAPU_ASSERT_IMPLY(a_noise_vol, i_clk, i_rst_n,
        out_acc && i_out_offset == OFS_NOISE_VOL, !i_out_last, "noise volume write marked last")

endmodule

bind psg_to_apu_register_translator psgapu_checker u_psgapu_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_offset (o_out.reg_offset),
    .i_out_data   (o_out.reg_data),
    .i_out_last   (o_out.last)
);
